/* design/three_phase_space_vector_pwm_duty_core_assert.svh */
// Assertion macros shared by the space vector PWM duty core.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef THREE_PHASE_SPACE_VECTOR_PWM_DUTY_CORE_ASSERT_SVH
`define THREE_PHASE_SPACE_VECTOR_PWM_DUTY_CORE_ASSERT_SVH

// Same-cycle implication, checked only outside reset.
`define SVPWM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked only outside reset.
`define SVPWM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/svpwm_pkg.sv */
// Shared widths, constants and types of the space vector PWM duty core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package svpwm_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int OUT_W      = 16;
  // Fraction bits of the internal fixed-point format.
  localparam int FRAC_BITS  = DATA_WIDTH - 1 + 16;
  // Widths of alpha * 2^16, of beta / sqrt(3), of the squares and of the duty sums.
  localparam int FA_W       = DATA_WIDTH + 16;
  localparam int FB_W       = DATA_WIDTH + 17;
  localparam int SQ_W       = 2 * DATA_WIDTH;
  localparam int ACC_W      = DATA_WIDTH + 20;

  // round(2^16 / sqrt(3))
  localparam logic [16:0] INV_SQRT3_Q16 = 17'd37837;

  // Sector codes, sector 1 through sector 6.
  localparam logic [2:0] SEC_0 = 3'd0;
  localparam logic [2:0] SEC_1 = 3'd1;
  localparam logic [2:0] SEC_2 = 3'd2;
  localparam logic [2:0] SEC_3 = 3'd3;
  localparam logic [2:0] SEC_4 = 3'd4;
  localparam logic [2:0] SEC_5 = 3'd5;

  typedef logic signed [ACC_W-1:0] acc_t;

  // One in the internal format.
  localparam acc_t ONE_Q = {{(ACC_W - FRAC_BITS - 1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  // Two in the internal format: the largest legal twice-duty value.
  localparam acc_t TWO_Q = {{(ACC_W - FRAC_BITS - 2){1'b0}}, 1'b1, {(FRAC_BITS + 1){1'b0}}};

  typedef struct packed {
    logic [OUT_W-1:0] duty;
    logic             clamped;
  } scale_res_t;

endpackage

/* design/svpwm_scale.sv */
// Clamps one twice-duty value to 0..2 and scales it to a 16-bit duty, rounding half up.
// Depends on svpwm_pkg.
`timescale 1ns / 1ps

module svpwm_scale (
  input  svpwm_pkg::acc_t       twice,
  output svpwm_pkg::scale_res_t res
);
  import svpwm_pkg::*;

  localparam int PW = FRAC_BITS + 18;
  localparam logic [PW-1:0] HALF_Q = {{(PW - FRAC_BITS - 1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  logic [FRAC_BITS+1:0] d;
  logic [PW-1:0]        prod;

  // D * 65535 + one, formed as (D << 16) - D + one.
  assign d    = twice[FRAC_BITS+1:0];
  assign prod = {d, {OUT_W{1'b0}}} - {{OUT_W{1'b0}}, d} + HALF_Q;

  always_comb begin
    if (twice < 0) begin
      res.duty    = '0;
      res.clamped = 1'b1;
    end else if (twice > TWO_Q) begin
      res.duty    = '1;
      res.clamped = 1'b1;
    end else begin
      res.duty    = prod[FRAC_BITS+OUT_W:FRAC_BITS+1];
      res.clamped = 1'b0;
    end
  end

endmodule

/* design/three_phase_space_vector_pwm_duty_core.sv */
// Three-phase space vector PWM duty core: (alpha, beta) in, three phase duties out.
// One beat per cycle while the output is not stalled by out_ready.
// The rate is set by the four-stage pipeline, each stage advancing whenever the next is open.
// Synchronous active-low reset empties the pipeline; data registers are not reset.
// Depends on svpwm_pkg, svpwm_scale and the assertion macro header.
`timescale 1ns / 1ps

`include "three_phase_space_vector_pwm_duty_core_assert.svh"

module three_phase_space_vector_pwm_duty_core (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [svpwm_pkg::DATA_WIDTH-1:0] in_v_alpha,
  input  logic signed [svpwm_pkg::DATA_WIDTH-1:0] in_v_beta,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic        [svpwm_pkg::OUT_W-1:0]      out_duty_a,
  output logic        [svpwm_pkg::OUT_W-1:0]      out_duty_b,
  output logic        [svpwm_pkg::OUT_W-1:0]      out_duty_c,
  output logic        [2:0]                       out_sector,
  output logic                                    out_overmodulated
);
  import svpwm_pkg::*;

  // Pipeline overview:
  //   stage 1: squares of alpha and beta, beta / sqrt(3), alpha, sign and zero flags of beta.
  //   stage 2: sector from sign and square comparisons; fa + fb, fa - fb and 2 fb.
  //   stage 3: per-sector dwell times t1, t2 and the three twice-duty values.
  //   stage 4: clamp and scale to 16 bits; this register is the output register.
  // Each stage holds a valid bit. A stage loads when it is empty or when the stage
  // after it loads, so bubbles close up and a stalled output does not block
  // upstream stages that still have room.

  // ---------------------------------------------------------------- handshake
  logic v1_r, v2_r, v3_r, v4_r;
  logic v1_nxt, v2_nxt, v3_nxt, v4_nxt;
  logic en1, en2, en3, en4;

  assign en4      = !v4_r || out_ready;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  assign v1_nxt = en1 ? in_valid : v1_r;
  assign v2_nxt = en2 ? v1_r     : v2_r;
  assign v3_nxt = en3 ? v2_r     : v3_r;
  assign v4_nxt = en4 ? v3_r     : v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 1
  // Squares feed the sector test against beta = +-sqrt(3) alpha, which becomes
  // beta^2 versus 3 alpha^2 once the signs are known.
  logic signed [SQ_W-1:0]       aa_s, bb_s;
  logic signed [FB_W-1:0]       fb_nxt;
  logic        [SQ_W-1:0]       aa1_r, bb1_r;
  logic signed [FB_W-1:0]       fb1_r;
  logic signed [DATA_WIDTH-1:0] a1_r;
  logic                         b_zero1_r, b_neg1_r;

  assign aa_s   = SQ_W'(in_v_alpha) * SQ_W'(in_v_alpha);
  assign bb_s   = SQ_W'(in_v_beta) * SQ_W'(in_v_beta);
  assign fb_nxt = FB_W'(in_v_beta) * FB_W'($signed({1'b0, INV_SQRT3_Q16}));

  always_ff @(posedge clk) begin
    if (en1) begin
      aa1_r     <= $unsigned(aa_s);
      bb1_r     <= $unsigned(bb_s);
      fb1_r     <= fb_nxt;
      a1_r      <= in_v_alpha;
      b_zero1_r <= (in_v_beta == '0);
      b_neg1_r  <= in_v_beta[DATA_WIDTH-1];
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic [SQ_W+1:0] aa3, bb_ext;
  logic            bb_lt, bb_le, a_pos, a_neg;
  logic [2:0]      sec_nxt;
  acc_t            fa_ext, fb_ext;
  logic [2:0]      sec2_r;
  acc_t            sum2_r, dif2_r, fb2x2_r;

  assign aa3    = {2'b00, aa1_r} + {1'b0, aa1_r, 1'b0};
  assign bb_ext = {2'b00, bb1_r};
  assign bb_lt  = bb_ext < aa3;
  assign bb_le  = bb_ext <= aa3;
  assign a_neg  = a1_r[DATA_WIDTH-1];
  assign a_pos  = !a1_r[DATA_WIDTH-1] && (a1_r != '0);

  // alpha * 2^16 and beta / sqrt(3), both sign-extended to the sum width.
  assign fa_ext = {{(ACC_W - FA_W){a1_r[DATA_WIDTH-1]}}, a1_r, 16'd0};
  assign fb_ext = {{(ACC_W - FB_W){fb1_r[FB_W-1]}}, fb1_r};

  // Sector edges are inclusive at the lower angle. A vector on the beta = 0 line
  // lands in sector 1 unless alpha is negative (sector 4); the zero vector is
  // sector 1. The negative beta axis falls through to sector 5.
  always_comb begin
    if (b_zero1_r) begin
      sec_nxt = a_neg ? SEC_3 : SEC_0;
    end else if (!b_neg1_r) begin
      if (a_pos && bb_lt) begin
        sec_nxt = SEC_0;
      end else if (a_neg && bb_le) begin
        sec_nxt = SEC_2;
      end else begin
        sec_nxt = SEC_1;
      end
    end else begin
      if (a_neg && bb_lt) begin
        sec_nxt = SEC_3;
      end else if (a_pos && bb_le) begin
        sec_nxt = SEC_5;
      end else begin
        sec_nxt = SEC_4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      sec2_r  <= sec_nxt;
      sum2_r  <= fa_ext + fb_ext;
      dif2_r  <= fa_ext - fb_ext;
      fb2x2_r <= fb_ext <<< 1;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // Dwell times per sector, then twice each duty: 1 +- t1 +- t2.
  acc_t       t1, t2, hi, lo, m1, m2;
  acc_t       da_nxt, db_nxt, dc_nxt;
  acc_t       da3_r, db3_r, dc3_r;
  logic [2:0] sec3_r;

  always_comb begin
    case (sec2_r)
      SEC_0: begin
        t1 = dif2_r;
        t2 = fb2x2_r;
      end
      SEC_1: begin
        t1 = sum2_r;
        t2 = -dif2_r;
      end
      SEC_2: begin
        t1 = fb2x2_r;
        t2 = -sum2_r;
      end
      SEC_3: begin
        t1 = -dif2_r;
        t2 = -fb2x2_r;
      end
      SEC_4: begin
        t1 = -sum2_r;
        t2 = dif2_r;
      end
      default: begin
        t1 = -fb2x2_r;
        t2 = sum2_r;
      end
    endcase
  end

  assign hi = ONE_Q + t1 + t2;
  assign lo = ONE_Q - t1 - t2;
  assign m1 = ONE_Q + t1 - t2;
  assign m2 = ONE_Q + t2 - t1;

  // Standard phase assignment: the phase that leads carries all active time.
  always_comb begin
    case (sec2_r)
      SEC_0: begin
        da_nxt = hi;
        db_nxt = m2;
        dc_nxt = lo;
      end
      SEC_1: begin
        da_nxt = m1;
        db_nxt = hi;
        dc_nxt = lo;
      end
      SEC_2: begin
        da_nxt = lo;
        db_nxt = hi;
        dc_nxt = m2;
      end
      SEC_3: begin
        da_nxt = lo;
        db_nxt = m1;
        dc_nxt = hi;
      end
      SEC_4: begin
        da_nxt = m2;
        db_nxt = lo;
        dc_nxt = hi;
      end
      default: begin
        da_nxt = hi;
        db_nxt = lo;
        dc_nxt = m1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      da3_r  <= da_nxt;
      db3_r  <= db_nxt;
      dc3_r  <= dc_nxt;
      sec3_r <= sec2_r;
    end
  end

  // ---------------------------------------------------------------- stage 4
  // Saturation of any phase raises the overmodulation flag.
  scale_res_t res_a, res_b, res_c;

  svpwm_scale u_scale_a (.twice(da3_r), .res(res_a));
  svpwm_scale u_scale_b (.twice(db3_r), .res(res_b));
  svpwm_scale u_scale_c (.twice(dc3_r), .res(res_c));

  logic [OUT_W-1:0] duty_a4_r, duty_b4_r, duty_c4_r;
  logic [2:0]       sec4_r;
  logic             ovm4_r;

  always_ff @(posedge clk) begin
    if (en4) begin
      duty_a4_r <= res_a.duty;
      duty_b4_r <= res_b.duty;
      duty_c4_r <= res_c.duty;
      sec4_r    <= sec3_r;
      ovm4_r    <= res_a.clamped || res_b.clamped || res_c.clamped;
    end
  end

  assign out_valid         = v4_r;
  assign out_duty_a        = duty_a4_r;
  assign out_duty_b        = duty_b4_r;
  assign out_duty_c        = duty_c4_r;
  assign out_sector        = sec4_r;
  assign out_overmodulated = ovm4_r;

  // ---------------------------------------------------------------- checks
  // An empty output register always opens the input.
  `SVPWM_ASSERT_IMP(a_empty_out_ready, !v4_r, in_ready, "input blocked with output register empty")
  // A completely full pipeline with a stalled output must refuse input.
  `SVPWM_ASSERT_IMP(a_full_stall, v1_r && v2_r && v3_r && v4_r && !out_ready, !in_ready,
                    "input accepted while pipeline full and stalled")
  // A beat leaving stage 3 must show up in the output register.
  `SVPWM_ASSERT_NXT(a_stage3_moves, v3_r && en3, v4_r, "beat lost between stage 3 and output")
  // A blocked stage 2 beat holds its sector.
  `SVPWM_ASSERT_NXT(a_stage2_hold, v2_r && !en3, v2_r && $stable(sec2_r),
                    "stalled stage 2 beat changed")

endmodule
